[rtl/mpsm_pkg.sv]
package mpsm_pkg;

    // fixed field widths and sizes
    localparam int ALPHABET_SIZE = 26;
    localparam int MAX_PATTERNS  = 16;
    localparam int POSITION_BITS = 20;
    localparam int DEF_MAX_NODES = 256;

    localparam int OP_W   = 3;
    localparam int SYM_W  = 5;
    localparam int KIND_W = 2;
    localparam int PIW    = $clog2(MAX_PATTERNS);
    localparam int PCW    = $clog2(MAX_PATTERNS + 1);

    typedef enum logic [OP_W-1:0] {
        OP_LETTER  = 3'd0,
        OP_END     = 3'd1,
        OP_BUILD   = 3'd2,
        OP_TEXT    = 3'd3,
        OP_RESTART = 3'd4
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_MATCH  = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_FULL   = 2'd2,
        KIND_EMPTY  = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_INS_W,
        ST_END_W,
        ST_END,
        ST_B_ROOT,
        ST_B_ROOT_W,
        ST_B_POP,
        ST_B_POP_W,
        ST_B_FU_W,
        ST_B_CH,
        ST_B_CH_W,
        ST_B_WALK_W,
        ST_B_FL_W,
        ST_B_LINK_W,
        ST_S_EDGE_W,
        ST_S_FL_W,
        ST_S_RPT_W,
        ST_S_EMIT
    } t_state;

endpackage

[rtl/mpsm_if.sv]
// input word channel
interface mpsm_in_if;
    logic                      valid;
    logic                      ready;
    logic [mpsm_pkg::OP_W-1:0]  op;
    logic [mpsm_pkg::SYM_W-1:0] symbol;

    modport source (output valid, output op, output symbol, input ready);
    modport sink   (input valid, input op, input symbol, output ready);
endinterface

// result word channel
interface mpsm_out_if;
    logic                              valid;
    logic                              ready;
    logic [mpsm_pkg::KIND_W-1:0]        kind;
    logic [mpsm_pkg::PIW-1:0]           pattern_index;
    logic [mpsm_pkg::POSITION_BITS-1:0] start_position;
    logic                              last;

    modport source (output valid, output kind, output pattern_index,
                    output start_position, output last, input ready);
    modport sink   (input valid, input kind, input pattern_index,
                    input start_position, input last, output ready);
endinterface

[rtl/multi_pattern_string_matcher_core.sv]
// Channel   Dir  Payload                                   Handshake
// i_in      in   op[2:0], symbol[4:0]                      valid/ready
// o_out     out  kind[1:0], pattern_index[3:0],            valid/ready
//                start_position[19:0], last
//
// After reset a clearing pass writes every goto entry, with i_in.ready low.
// Pattern letter: one goto read, none if the letter is ignored. End pattern:
// one mask read unless rejected. Restart, unused ops and text before a build
// read no memory. Text letter: a goto read, a failure and a goto read per
// failure step, a mask and report-link read per report node, and one result
// per match, all through the registered goto / failure / mask memory reads.
// Build: a goto read per root letter, then for each queued node a failure
// read and a goto read per letter, and a failure walk and link per child.
// One item is worked at a time; a result waits in the output register and
// further results stall until it is taken.
module multi_pattern_string_matcher_core #(
    parameter int MAX_NODES = mpsm_pkg::DEF_MAX_NODES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mpsm_in_if.sink           i_in,
    mpsm_out_if.source        o_out
);
    import mpsm_pkg::*;

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_NODES + 1);
    localparam int GD  = MAX_NODES * ALPHABET_SIZE;
    localparam int GAW = $clog2(GD);
    localparam int PB  = POSITION_BITS;
    localparam logic [PB-1:0] POS_MAX = '1;

    function automatic logic [GAW-1:0] f_gaddr(input logic [NW-1:0] node,
                                               input logic [SYM_W-1:0] sym);
        f_gaddr = GAW'(node) * GAW'(ALPHABET_SIZE) + GAW'(sym);
    endfunction

    // memories
    logic [NW-1:0]           r_gt_mem [GD];
    logic [NW-1:0]           r_fl_mem [MAX_NODES];
    logic [NW:0]             r_rl_mem [MAX_NODES];
    logic [MAX_PATTERNS-1:0] r_pm_mem [MAX_NODES];
    logic [NW-1:0]           r_bq_mem [MAX_NODES];
    logic [NW-1:0]           r_plen   [MAX_PATTERNS];

    logic [NW-1:0]           r_gt_q, r_fl_q, r_bq_q;
    logic [NW:0]             r_rl_q;
    logic [MAX_PATTERNS-1:0] r_pm_q;

    logic                    w_gt_we, w_fl_we, w_rl_we, w_pm_we, w_bq_we, w_plen_we;
    logic [GAW-1:0]          w_gt_waddr, w_gt_raddr;
    logic [NW-1:0]           w_gt_wdata;
    logic [NW-1:0]           w_fl_waddr, w_fl_raddr, w_fl_wdata;
    logic [NW-1:0]           w_rl_waddr, w_rl_raddr;
    logic [NW:0]             w_rl_wdata;
    logic [NW-1:0]           w_pm_waddr, w_pm_raddr;
    logic [MAX_PATTERNS-1:0] w_pm_wdata;
    logic [NW-1:0]           w_bq_waddr, w_bq_raddr, w_bq_wdata;

    // control and datapath registers
    t_state                  r_state, n_state;
    logic [GAW-1:0]          r_clr, n_clr;
    logic [CW-1:0]           r_ncount, n_ncount;
    logic [PCW-1:0]          r_pcount, n_pcount;
    logic [NW-1:0]           r_cursor, n_cursor;
    logic [NW-1:0]           r_ilen, n_ilen;
    logic [NW-1:0]           r_scan, n_scan;
    logic [PB-1:0]           r_text, n_text;
    logic                    r_ovf, n_ovf;
    logic                    r_built, n_built;
    logic [GAW-1:0]          r_gaddr, n_gaddr;
    logic [SYM_W-1:0]        r_sym, n_sym;
    logic                    r_symok, n_symok;
    logic [NW-1:0]           r_t, n_t;
    logic [CW-1:0]           r_head, n_head;
    logic [CW-1:0]           r_tail, n_tail;
    logic [NW-1:0]           r_u, n_u;
    logic [NW-1:0]           r_fu, n_fu;
    logic [SYM_W-1:0]        r_c, n_c;
    logic [NW-1:0]           r_ch, n_ch;
    logic [NW-1:0]           r_f, n_f;
    logic [MAX_PATTERNS-1:0] r_mask, n_mask;
    logic [NW:0]             r_rl, n_rl;
    logic                    r_pend_v, n_pend_v;
    logic [PIW-1:0]          r_pend_idx, n_pend_idx;
    logic [PB-1:0]           r_pend_pos, n_pend_pos;

    // output register
    logic                    r_ovalid;
    t_kind                   r_okind;
    logic [PIW-1:0]          r_oidx;
    logic [PB-1:0]           r_opos;
    logic                    r_olast;

    logic                    w_push;
    t_kind                   w_push_kind;
    logic [PIW-1:0]          w_push_idx;
    logic [PB-1:0]           w_push_pos;
    logic                    w_push_last;
    logic                    w_out_free;
    logic                    w_sym_ok;
    logic [PIW-1:0]          w_low;
    logic [PB-1:0]           w_len;
    logic [PB-1:0]           w_pos;
    logic [NW-1:0]           w_e;

    assign w_out_free = !r_ovalid || o_out.ready;
    assign w_sym_ok   = i_in.symbol < SYM_W'(ALPHABET_SIZE);
    assign i_in.ready = (r_state == ST_IDLE);

    // lowest pattern bit left in the current node
    always_comb begin
        w_low = '0;
        for (int i = MAX_PATTERNS - 1; i >= 0; i--) begin
            if (r_mask[i]) w_low = PIW'(i);
        end
    end

    // start position of that match
    assign w_len = PB'(r_plen[w_low]);
    assign w_pos = (w_len > r_text) ? '0 : r_text - w_len + PB'(1);

    // memory ports
    always_ff @(posedge i_clk) begin
        if (w_gt_we) r_gt_mem[w_gt_waddr] <= w_gt_wdata;
        r_gt_q <= r_gt_mem[w_gt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_fl_we) r_fl_mem[w_fl_waddr] <= w_fl_wdata;
        r_fl_q <= r_fl_mem[w_fl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rl_we) r_rl_mem[w_rl_waddr] <= w_rl_wdata;
        r_rl_q <= r_rl_mem[w_rl_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_pm_we) r_pm_mem[w_pm_waddr] <= w_pm_wdata;
        r_pm_q <= r_pm_mem[w_pm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_bq_we) r_bq_mem[w_bq_waddr] <= w_bq_wdata;
        r_bq_q <= r_bq_mem[w_bq_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_plen_we) r_plen[r_pcount[PIW-1:0]] <= r_ilen;
    end

    // next state and memory control
    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_ncount   = r_ncount;
        n_pcount   = r_pcount;
        n_cursor   = r_cursor;
        n_ilen     = r_ilen;
        n_scan     = r_scan;
        n_text     = r_text;
        n_ovf      = r_ovf;
        n_built    = r_built;
        n_gaddr    = r_gaddr;
        n_sym      = r_sym;
        n_symok    = r_symok;
        n_t        = r_t;
        n_head     = r_head;
        n_tail     = r_tail;
        n_u        = r_u;
        n_fu       = r_fu;
        n_c        = r_c;
        n_ch       = r_ch;
        n_f        = r_f;
        n_mask     = r_mask;
        n_rl       = r_rl;
        n_pend_v   = r_pend_v;
        n_pend_idx = r_pend_idx;
        n_pend_pos = r_pend_pos;

        w_gt_we = 1'b0; w_gt_waddr = '0; w_gt_wdata = '0; w_gt_raddr = '0;
        w_fl_we = 1'b0; w_fl_waddr = '0; w_fl_wdata = '0; w_fl_raddr = '0;
        w_rl_we = 1'b0; w_rl_waddr = '0; w_rl_wdata = '0; w_rl_raddr = '0;
        w_pm_we = 1'b0; w_pm_waddr = '0; w_pm_wdata = '0; w_pm_raddr = '0;
        w_bq_we = 1'b0; w_bq_waddr = '0; w_bq_wdata = '0; w_bq_raddr = '0;
        w_plen_we = 1'b0;

        w_push      = 1'b0;
        w_push_kind = KIND_MATCH;
        w_push_idx  = '0;
        w_push_pos  = '0;
        w_push_last = 1'b0;
        w_e         = '0;

        unique case (r_state)
            // sweep goto table and per-node stores after reset
            ST_CLEAR: begin
                w_gt_we    = 1'b1;
                w_gt_waddr = r_clr;
                if (r_clr < GAW'(MAX_NODES)) begin
                    w_fl_we    = 1'b1;
                    w_fl_waddr = r_clr[NW-1:0];
                    w_rl_we    = 1'b1;
                    w_rl_waddr = r_clr[NW-1:0];
                    w_pm_we    = 1'b1;
                    w_pm_waddr = r_clr[NW-1:0];
                end
                n_clr = r_clr + GAW'(1);
                if (r_clr == GAW'(GD - 1)) n_state = ST_IDLE;
            end

            ST_IDLE: begin
                if (i_in.valid) begin
                    unique case (i_in.op)
                        OP_LETTER: begin
                            n_built = 1'b0;
                            if (w_sym_ok && !r_ovf) begin
                                w_gt_raddr = f_gaddr(r_cursor, i_in.symbol);
                                n_gaddr    = f_gaddr(r_cursor, i_in.symbol);
                                n_state    = ST_INS_W;
                            end
                        end
                        OP_END: begin
                            n_built = 1'b0;
                            if (r_ilen != '0 && !r_ovf &&
                                r_pcount < PCW'(MAX_PATTERNS)) begin
                                w_pm_raddr = r_cursor;
                                n_state    = ST_END_W;
                            end else begin
                                n_state = ST_END;
                            end
                        end
                        OP_BUILD: begin
                            w_fl_we    = 1'b1;
                            w_fl_waddr = '0;
                            w_rl_we    = 1'b1;
                            w_rl_waddr = '0;
                            n_c        = '0;
                            n_head     = '0;
                            n_tail     = '0;
                            n_state    = ST_B_ROOT;
                        end
                        OP_TEXT: begin
                            if (r_built) begin
                                if (r_text != POS_MAX) n_text = r_text + PB'(1);
                                n_sym   = i_in.symbol;
                                n_symok = w_sym_ok;
                                n_t     = r_scan;
                                w_gt_raddr = w_sym_ok ? f_gaddr(r_scan, i_in.symbol) : '0;
                                n_state = ST_S_EDGE_W;
                            end
                        end
                        OP_RESTART: begin
                            n_scan = '0;
                            n_text = '0;
                        end
                        default: ;
                    endcase
                end
            end

            // follow or add the trie edge
            ST_INS_W: begin
                if (r_gt_q == '0) begin
                    if (r_ncount >= CW'(MAX_NODES)) begin
                        n_ovf = 1'b1;
                    end else begin
                        w_gt_we    = 1'b1;
                        w_gt_waddr = r_gaddr;
                        w_gt_wdata = r_ncount[NW-1:0];
                        n_cursor   = r_ncount[NW-1:0];
                        n_ncount   = r_ncount + CW'(1);
                        n_ilen     = r_ilen + NW'(1);
                    end
                end else begin
                    n_cursor = r_gt_q;
                    n_ilen   = r_ilen + NW'(1);
                end
                n_state = ST_IDLE;
            end

            // mark the pattern end node
            ST_END_W: begin
                w_pm_we    = 1'b1;
                w_pm_waddr = r_cursor;
                w_pm_wdata = r_pm_q | (MAX_PATTERNS'(1) << r_pcount[PIW-1:0]);
                w_plen_we  = 1'b1;
                n_state    = ST_END;
            end

            ST_END: begin
                if (w_out_free) begin
                    w_push      = 1'b1;
                    w_push_last = 1'b1;
                    if (r_ilen == '0) begin
                        w_push_kind = KIND_EMPTY;
                    end else if (r_ovf || r_pcount >= PCW'(MAX_PATTERNS)) begin
                        w_push_kind = KIND_FULL;
                    end else begin
                        w_push_kind = KIND_ACCEPT;
                        w_push_idx  = r_pcount[PIW-1:0];
                        n_pcount    = r_pcount + PCW'(1);
                    end
                    n_cursor = '0;
                    n_ilen   = '0;
                    n_ovf    = 1'b0;
                    n_state  = ST_IDLE;
                end
            end

            // root children seed the queue
            ST_B_ROOT: begin
                if (r_c == SYM_W'(ALPHABET_SIZE)) begin
                    n_state = ST_B_POP;
                end else begin
                    w_gt_raddr = GAW'(r_c);
                    n_state    = ST_B_ROOT_W;
                end
            end

            ST_B_ROOT_W: begin
                if (r_gt_q != '0) begin
                    w_fl_we    = 1'b1;
                    w_fl_waddr = r_gt_q;
                    w_rl_we    = 1'b1;
                    w_rl_waddr = r_gt_q;
                    w_bq_we    = 1'b1;
                    w_bq_waddr = r_tail[NW-1:0];
                    w_bq_wdata = r_gt_q;
                    n_tail     = r_tail + CW'(1);
                end
                n_c     = r_c + SYM_W'(1);
                n_state = ST_B_ROOT;
            end

            // next node off the queue, or done
            ST_B_POP: begin
                if (r_head == r_tail) begin
                    n_built = 1'b1;
                    n_scan  = '0;
                    n_text  = '0;
                    n_state = ST_IDLE;
                end else begin
                    w_bq_raddr = r_head[NW-1:0];
                    n_head     = r_head + CW'(1);
                    n_state    = ST_B_POP_W;
                end
            end

            ST_B_POP_W: begin
                n_u        = r_bq_q;
                w_fl_raddr = r_bq_q;
                n_state    = ST_B_FU_W;
            end

            ST_B_FU_W: begin
                n_fu    = r_fl_q;
                n_c     = '0;
                n_state = ST_B_CH;
            end

            ST_B_CH: begin
                if (r_c == SYM_W'(ALPHABET_SIZE)) begin
                    n_state = ST_B_POP;
                end else begin
                    w_gt_raddr = f_gaddr(r_u, r_c);
                    n_state    = ST_B_CH_W;
                end
            end

            ST_B_CH_W: begin
                if (r_gt_q == '0) begin
                    n_c     = r_c + SYM_W'(1);
                    n_state = ST_B_CH;
                end else begin
                    n_ch       = r_gt_q;
                    n_t        = r_fu;
                    w_gt_raddr = f_gaddr(r_fu, r_c);
                    n_state    = ST_B_WALK_W;
                end
            end

            // failure walk for the child
            ST_B_WALK_W: begin
                if (r_gt_q != '0 || r_t == '0) begin
                    n_f        = r_gt_q;
                    w_pm_raddr = r_gt_q;
                    w_rl_raddr = r_gt_q;
                    n_state    = ST_B_LINK_W;
                end else begin
                    w_fl_raddr = r_t;
                    n_state    = ST_B_FL_W;
                end
            end

            ST_B_FL_W: begin
                n_t        = r_fl_q;
                w_gt_raddr = f_gaddr(r_fl_q, r_c);
                n_state    = ST_B_WALK_W;
            end

            ST_B_LINK_W: begin
                w_fl_we    = 1'b1;
                w_fl_waddr = r_ch;
                w_fl_wdata = r_f;
                w_rl_we    = 1'b1;
                w_rl_waddr = r_ch;
                w_rl_wdata = (r_pm_q != '0) ? {1'b1, r_f} : r_rl_q;
                w_bq_we    = 1'b1;
                w_bq_waddr = r_tail[NW-1:0];
                w_bq_wdata = r_ch;
                n_tail     = r_tail + CW'(1);
                n_c        = r_c + SYM_W'(1);
                n_state    = ST_B_CH;
            end

            // text letter: walk failure links to the next node
            ST_S_EDGE_W: begin
                w_e = r_symok ? r_gt_q : '0;
                if (w_e != '0 || r_t == '0) begin
                    n_scan     = w_e;
                    w_pm_raddr = w_e;
                    w_rl_raddr = w_e;
                    n_state    = ST_S_RPT_W;
                end else begin
                    w_fl_raddr = r_t;
                    n_state    = ST_S_FL_W;
                end
            end

            ST_S_FL_W: begin
                n_t        = r_fl_q;
                w_gt_raddr = r_symok ? f_gaddr(r_fl_q, r_sym) : '0;
                n_state    = ST_S_EDGE_W;
            end

            ST_S_RPT_W: begin
                n_mask  = r_pm_q;
                n_rl    = r_rl_q;
                n_state = ST_S_EMIT;
            end

            // one match per cycle while the output is free, held back one so last can be set
            ST_S_EMIT: begin
                if (r_mask != '0) begin
                    if (!r_pend_v || w_out_free) begin
                        if (r_pend_v) begin
                            w_push     = 1'b1;
                            w_push_idx = r_pend_idx;
                            w_push_pos = r_pend_pos;
                        end
                        n_pend_v   = 1'b1;
                        n_pend_idx = w_low;
                        n_pend_pos = w_pos;
                        n_mask     = r_mask & ~(MAX_PATTERNS'(1) << w_low);
                    end
                end else if (r_rl[NW]) begin
                    w_pm_raddr = r_rl[NW-1:0];
                    w_rl_raddr = r_rl[NW-1:0];
                    n_state    = ST_S_RPT_W;
                end else if (r_pend_v) begin
                    if (w_out_free) begin
                        w_push      = 1'b1;
                        w_push_idx  = r_pend_idx;
                        w_push_pos  = r_pend_pos;
                        w_push_last = 1'b1;
                        n_pend_v    = 1'b0;
                        n_state     = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end

            default: n_state = ST_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_ncount <= CW'(1);
            r_pcount <= '0;
            r_cursor <= '0;
            r_ilen   <= '0;
            r_scan   <= '0;
            r_text   <= '0;
            r_ovf    <= 1'b0;
            r_built  <= 1'b0;
            r_head   <= '0;
            r_tail   <= '0;
            r_c      <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ncount <= n_ncount;
            r_pcount <= n_pcount;
            r_cursor <= n_cursor;
            r_ilen   <= n_ilen;
            r_scan   <= n_scan;
            r_text   <= n_text;
            r_ovf    <= n_ovf;
            r_built  <= n_built;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_c      <= n_c;
            r_pend_v <= n_pend_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_gaddr    <= n_gaddr;
        r_sym      <= n_sym;
        r_symok    <= n_symok;
        r_t        <= n_t;
        r_u        <= n_u;
        r_fu       <= n_fu;
        r_ch       <= n_ch;
        r_f        <= n_f;
        r_mask     <= n_mask;
        r_rl       <= n_rl;
        r_pend_idx <= n_pend_idx;
        r_pend_pos <= n_pend_pos;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_push) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_okind <= w_push_kind;
            r_oidx  <= w_push_idx;
            r_opos  <= w_push_pos;
            r_olast <= w_push_last;
        end
    end

    assign o_out.valid          = r_ovalid;
    assign o_out.kind           = r_okind;
    assign o_out.pattern_index  = r_oidx;
    assign o_out.start_position = r_opos;
    assign o_out.last           = r_olast;

endmodule

[rtl/mpsm_checker.sv]
module mpsm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [mpsm_pkg::KIND_W-1:0]        i_kind,
    input logic [mpsm_pkg::PIW-1:0]           i_idx,
    input logic [mpsm_pkg::POSITION_BITS-1:0] i_pos,
    input logic                              i_last
);
    import mpsm_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_pos) && $stable(i_kind))
        else $error("result word changed while stalled");

    // a match always has a real start position
    a_match_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind == KIND_MATCH |-> i_pos != '0)
        else $error("match with zero start position");

    // pattern end answers are single words without position
    a_end_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_kind != KIND_MATCH |-> i_last && i_pos == '0)
        else $error("pattern end answer malformed");

    // rejections carry index zero
    a_reject_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_FULL || i_kind == KIND_EMPTY) |-> i_idx == '0)
        else $error("rejection with nonzero index");

endmodule

bind multi_pattern_string_matcher_core mpsm_checker u_mpsm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_kind      (o_out.kind),
    .i_idx       (o_out.pattern_index),
    .i_pos       (o_out.start_position),
    .i_last      (o_out.last)
);
